### rtl/bds_pkg.sv
// Package for the 2x2 box-filter mip downsampler.
// Holds shared widths, configuration register indexes and default sizes.
// No dependencies.
package bds_pkg;

    // Pixel and channel geometry
    localparam int PIX_W  = 32;
    localparam int CH_W   = 8;
    localparam int SUM_W  = CH_W + 1;
    localparam int NUM_CH = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SRC_W_BITS = 13;
    localparam int SRC_H_BITS = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1
    } cfg_reg_t;

    // Largest supported source width
    localparam int MAX_WIDTH_DEF = 4096;

endpackage

### rtl/bds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used as the pair-sum line store. Depends on nothing.
module bds_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, hold data when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bds_lane.sv
// One color-channel lane: horizontal pair sum and 2x2 rounded average.
// Depends on bds_pkg.
module bds_lane
    import bds_pkg::*;
(
    input  logic             clk,
    input  logic             load,
    input  logic             self_upper,
    input  logic [CH_W-1:0]  left,
    input  logic [CH_W-1:0]  right,
    input  logic [SUM_W-1:0] upper,
    output logic [SUM_W-1:0] pair,
    output logic [CH_W-1:0]  avg
);

    logic [SUM_W-1:0] pair_reg;
    logic [SUM_W-1:0] top_sum;
    logic [SUM_W:0]   total;

    // Horizontal pair sum of the current item
    assign pair = SUM_W'(left) + SUM_W'(right);

    // Hold the pair for the averaging stage
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pair_reg <= pair;
        end
    end

    // Combine with the row above (or itself for a one-row image), round
    assign top_sum = self_upper ? pair_reg : upper;
    assign total   = (SUM_W+1)'(top_sum) + (SUM_W+1)'(pair_reg) + (SUM_W+1)'(2);
    assign avg     = total[SUM_W:2];

endmodule

### rtl/box_downsample_rgba8.sv
// Top level of the 2x2 box-filter mip downsampler for RGBA8 raster streams.
// Depends on bds_pkg, bds_lane and bds_ram.
//
//  channel   signals                                   direction  payload
//  pixel     pix_valid / pix_stall                     in         pixel_rgba
//  result    res_valid / res_stall                     out        out_rgba, last_in_row,
//                                                                  last_in_image
//  config    cfg_valid / cfg_ready                     in         cfg_index, cfg_data
//
// One source pixel is taken per clock while pix_stall is low. The result of the pixel
// that completes a 2x2 block passes the line-store read and then the output register.
// The line store is written on even rows and read on odd rows, one port each.
// Reset (rst_n low, asynchronous) sets width and height to 1 and restarts the image;
// the line store is not cleared, since every entry is written before it is read.
// A stall on the result side backs up through both stages to pix_stall in the same cycle.
module box_downsample_rgba8
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  logic [PIX_W-1:0]      pixel_rgba,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [PIX_W-1:0]      out_rgba,
    output logic                  last_in_row,
    output logic                  last_in_image,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int EW         = $clog2(MAX_WIDTH + 1);
    localparam int HW         = SRC_H_BITS;
    localparam int LW         = NUM_CH * SUM_W;

    // Configuration and position state
    logic [EW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [HW-1:0] row_reg, row_next;
    logic [PIX_W-1:0] held_left_reg;

    // Pipeline control
    logic          s1_valid_reg;
    logic          s1_self_reg;
    logic          s1_row_end_reg;
    logic          s1_img_end_reg;
    logic          out_valid_reg;
    logic [PIX_W-1:0] out_rgba_reg;
    logic          out_row_end_reg;
    logic          out_img_end_reg;

    logic          out_free, s1_free, s1_adv, accept;
    logic          cfg_we;

    // Decode of the current position
    logic          w_one, h_one, col_last, row_last, col_drop, row_drop;
    logic          pair_done, emit, line_we, line_re;
    logic [AW-1:0] idx;
    logic [AW-1:0] dst_w_m1;
    logic [HW-2:0] dst_h_m1;
    logic [HW-2:0] orow;
    logic          row_end, img_end;
    logic [EW-1:0] half_w;
    logic [HW-1:0] half_h;

    logic [PIX_W-1:0] left_px;
    logic [LW-1:0]    pair_word;
    logic [LW-1:0]    upper_word;
    logic [PIX_W-1:0] avg_word;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Handshake flow
    assign out_free  = !out_valid_reg || !res_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign s1_free   = !s1_valid_reg || out_free;
    assign pix_stall = !s1_free;
    assign accept    = pix_valid && s1_free;

    // Position decode
    assign w_one    = (width_reg == EW'(1));
    assign h_one    = (height_reg == HW'(1));
    assign col_last = (EW'(col_reg) == width_reg - EW'(1));
    assign row_last = (row_reg == height_reg - HW'(1));
    assign col_drop = !w_one && width_reg[0] && col_last;
    assign row_drop = !h_one && height_reg[0] && row_last;
    assign pair_done = !col_drop && !row_drop && (w_one || col_reg[0]);
    assign emit      = pair_done && (h_one || row_reg[0]);
    assign line_we   = accept && pair_done && !h_one && !row_reg[0];
    assign line_re   = accept && emit && !h_one;
    assign idx       = w_one ? AW'(0) : AW'(col_reg >> 1);

    // Output size minus one per axis
    assign half_w   = width_reg >> 1;
    assign half_h   = height_reg >> 1;
    assign dst_w_m1 = (half_w == EW'(0)) ? AW'(0) : AW'(half_w - EW'(1));
    assign dst_h_m1 = (half_h == HW'(0)) ? (HW-1)'(0) : (HW-1)'(half_h - HW'(1));
    assign orow     = h_one ? (HW-1)'(0) : (HW-1)'(row_reg >> 1);
    assign row_end  = (idx == dst_w_m1);
    assign img_end  = row_end && (orow == dst_h_m1);

    // Advance raster counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + HW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // Configuration registers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= EW'(1);
            height_reg <= HW'(1);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:
                begin
                    if (cfg_data[SRC_W_BITS-1:0] == '0)
                    begin
                        width_reg <= EW'(1);
                    end
                    else if (32'(cfg_data[SRC_W_BITS-1:0]) > 32'(MAX_WIDTH))
                    begin
                        width_reg <= EW'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_reg <= EW'(cfg_data[SRC_W_BITS-1:0]);
                    end
                    col_reg <= '0;
                    row_reg <= '0;
                end
                REG_SRC_HEIGHT:
                begin
                    height_reg <= (cfg_data == '0) ? HW'(1) : HW'(cfg_data);
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                default:
                begin
                    col_reg <= col_reg;
                end
            endcase
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Hold the left pixel of a pair
    always_ff @(posedge clk)
    begin
        if (accept && !col_drop && !row_drop && !w_one && !col_reg[0])
        begin
            held_left_reg <= pixel_rgba;
        end
    end

    assign left_px = w_one ? pixel_rgba : held_left_reg;

    // Channel lanes
    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        bds_lane u_lane (
            .clk        (clk),
            .load       (accept && emit),
            .self_upper (s1_self_reg),
            .left       (left_px[c*CH_W +: CH_W]),
            .right      (pixel_rgba[c*CH_W +: CH_W]),
            .upper      (upper_word[c*SUM_W +: SUM_W]),
            .pair       (pair_word[c*SUM_W +: SUM_W]),
            .avg        (avg_word[c*CH_W +: CH_W])
        );
    end

    // Line store of pair sums from even rows
    bds_ram #(
        .WIDTH (LW),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (idx),
        .wdata (pair_word),
        .re    (line_re),
        .raddr (idx),
        .rdata (upper_word)
    );

    // Averaging stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            s1_self_reg    <= h_one;
            s1_row_end_reg <= row_end;
            s1_img_end_reg <= img_end;
        end
    end

    // Merge lanes into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_rgba_reg    <= avg_word;
            out_row_end_reg <= s1_row_end_reg;
            out_img_end_reg <= s1_img_end_reg;
        end
    end

    assign res_valid     = out_valid_reg;
    assign out_rgba      = out_rgba_reg;
    assign last_in_row   = out_row_end_reg;
    assign last_in_image = out_img_end_reg;

    // Checks
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(col_reg) < width_reg)
        else $error("column counter beyond width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < height_reg)
        else $error("row counter beyond height");

    a_line_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(line_we && line_re))
        else $error("line store read and written by one item");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_img_end_reg))
        else $error("averaging stage lost an item while blocked");

    a_img_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && last_in_image |-> last_in_row)
        else $error("image end flagged off a row end");

endmodule

### bench/testbench.sv
// Self-checking bench for the 2x2 box-filter mip downsampler (box_downsample_rgba8).
// Streams RGBA8 source images through the block and checks every output pixel
// against a behavioral predictor. Depends on bds_pkg and the RTL only.
module testbench;
    import bds_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int RANDOM_ITEMS    = 1550;
    localparam int RUN_LIMIT       = 10_000_000;
    localparam int LINE_SLOTS      = (MAX_WIDTH_DEF + 1) / 2;

    // Indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] rgba;
        logic             row_end;
        logic             img_end;
    } mip_pixel_t;

    typedef enum bit {STEP_PIXEL, STEP_WRITE} step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [PIX_W-1:0]      pixel;
        bit                    typed;
        mip_pixel_t            want;
    } stim_row_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  pix_valid     = 1'b0;
    logic                  pix_stall;
    logic [PIX_W-1:0]      pixel_rgba    = '0;
    logic                  res_valid;
    logic                  res_stall     = 1'b0;
    logic [PIX_W-1:0]      out_rgba;
    logic                  last_in_row;
    logic                  last_in_image;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // Predictor state
    logic [NUM_CH*SUM_W-1:0] line_sums [LINE_SLOTS];
    logic [PIX_W-1:0]        held_px;
    logic [SRC_W_BITS-1:0]   width_reg;
    logic [SRC_H_BITS-1:0]   height_reg;
    logic [SRC_W_BITS-1:0]   col_pos;
    logic [SRC_H_BITS-1:0]   row_pos;

    mip_pixel_t mip_pixels_due [$];

    int pixels_sent;
    int pixels_checked;
    int settings_written;
    int mismatches;
    int hold_off_req;
    int hold_off_seen;
    int hold_left;
    int res_gap;

    stim_row_t directed_rows [35];

    box_downsample_rgba8 DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .pixel_rgba    (pixel_rgba),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .out_rgba      (out_rgba),
        .last_in_row   (last_in_row),
        .last_in_image (last_in_image),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                   input logic [PIX_W-1:0] want);
        $display("MISMATCH %s: got %h want %h (output pixel %0d)", what, got, want,
                 pixels_checked);
        mismatches++;
    endtask

    // Per-channel sums of two pixels, 9 bits each
    function automatic logic [NUM_CH*SUM_W-1:0] pair_sums(input logic [PIX_W-1:0] a,
                                                          input logic [PIX_W-1:0] b);
        logic [NUM_CH*SUM_W-1:0] s;
        s = '0;
        for (int c = 0; c < NUM_CH; c++)
            s[c*SUM_W +: SUM_W] = {1'b0, a[c*CH_W +: CH_W]} + {1'b0, b[c*CH_W +: CH_W]};
        return s;
    endfunction

    // Rounded average of two pair sums per channel
    function automatic logic [PIX_W-1:0] box_average(input logic [NUM_CH*SUM_W-1:0] p,
                                                     input logic [NUM_CH*SUM_W-1:0] q);
        logic [PIX_W-1:0] r;
        logic [SUM_W+1:0] t;
        r = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            t = {2'b0, p[c*SUM_W +: SUM_W]} + {2'b0, q[c*SUM_W +: SUM_W]} + 11'd2;
            r[c*CH_W +: CH_W] = t[CH_W+1:2];
        end
        return r;
    endfunction

    // Work out the output pixel, if any, that one source pixel completes
    task automatic predict_mip_pixel(input logic [PIX_W-1:0] px, output bit has,
                                     output mip_pixel_t r);
        logic [SRC_W_BITS-1:0]   w;
        logic [SRC_H_BITS-1:0]   h;
        logic [SRC_W_BITS-1:0]   dw;
        logic [SRC_H_BITS-1:0]   dh;
        logic [SRC_H_BITS-1:0]   out_row;
        logic [10:0]             slot;
        logic [NUM_CH*SUM_W-1:0] pair;
        logic [NUM_CH*SUM_W-1:0] upper;
        bit                      col_drop;
        bit                      row_drop;
        bit                      pair_ready;
        has = 1'b0;
        r = '0;
        pair = '0;
        pair_ready = 1'b0;
        w = (width_reg == '0) ? SRC_W_BITS'(1) : width_reg;
        if (w > SRC_W_BITS'(MAX_WIDTH_DEF))
            w = SRC_W_BITS'(MAX_WIDTH_DEF);
        h = (height_reg == '0) ? SRC_H_BITS'(1) : height_reg;
        dw = ((w >> 1) == '0) ? SRC_W_BITS'(1) : (w >> 1);
        dh = ((h >> 1) == '0) ? SRC_H_BITS'(1) : (h >> 1);
        col_drop = (w > 1) && w[0] && (col_pos == w - 1);
        row_drop = (h > 1) && h[0] && (row_pos == h - 1);

        if (!col_drop && !row_drop)
        begin
            if (w == 1)
            begin
                pair = pair_sums(px, px);
                pair_ready = 1'b1;
            end
            else if (!col_pos[0])
                held_px = px;
            else
            begin
                pair = pair_sums(held_px, px);
                pair_ready = 1'b1;
            end
        end

        // Even rows park pair sums, odd rows (or a single-row image) emit
        if (pair_ready)
        begin
            slot = (w == 1) ? 11'd0 : col_pos[11:1];
            out_row = (h == 1) ? 16'd0 : (row_pos >> 1);
            if (h == 1 || row_pos[0])
            begin
                upper = (h == 1) ? pair : line_sums[slot];
                has = 1'b1;
                r.rgba = box_average(upper, pair);
                r.row_end = (slot == dw - 1);
                r.img_end = r.row_end && (out_row == dh - 1);
            end
            else
                line_sums[slot] = pair;
        end

        // Advance raster position, wrap at end of image
        if (col_pos + 1 >= w)
        begin
            col_pos = '0;
            row_pos = (row_pos + 1 >= h) ? '0 : row_pos + SRC_H_BITS'(1);
        end
        else
            col_pos = col_pos + SRC_W_BITS'(1);
    endtask

    function automatic bit sender_calm();
        return ((pixels_sent / 128) % 4) == 3;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] p;
        p = $urandom();
        if ($urandom_range(0, 7) == 0)
            for (int c = 0; c < NUM_CH; c++)
                p[c*CH_W +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return p;
    endfunction

    // Offer one pixel after a random gap, predict once it is taken
    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                              input mip_pixel_t want);
        int         gap;
        bit         has;
        mip_pixel_t pred;
        gap = sender_calm() ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pixel_rgba <= px;
        do
            @(posedge clk);
        while (pix_stall);
        predict_mip_pixel(px, has, pred);
        if (typed)
            pred = want;
        if (has || typed)
            mip_pixels_due.push_back(pred);
        pixels_sent++;
    endtask

    // Stop offering and wait for every due pixel plus pipeline settle time
    task automatic wait_drained();
        pix_valid <= 1'b0;
        while (mip_pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write a register while the block is idle; a real register restarts the image
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_written++;
        case (idx)
            REG_SRC_WIDTH:
            begin
                width_reg = data[SRC_W_BITS-1:0];
                col_pos = '0;
                row_pos = '0;
            end
            REG_SRC_HEIGHT:
            begin
                height_reg = data[SRC_H_BITS-1:0];
                col_pos = '0;
                row_pos = '0;
            end
            default: ;
        endcase
    endtask

    task automatic send_image_run(input int count);
        repeat (count)
        begin
            send_pixel(rand_pixel(), 1'b0, '0);
            if ($urandom_range(0, 199) == 0)
                wait_drained();
        end
    endtask

    // Result side: check each taken pixel, then draw the stall for the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (mip_pixels_due.size() == 0)
                    report_mismatch("output pixel with none due", out_rgba, '0);
                else
                begin
                    mip_pixel_t e;
                    e = mip_pixels_due.pop_front();
                    if (out_rgba !== e.rgba)
                        report_mismatch("out_rgba", out_rgba, e.rgba);
                    if (last_in_row !== e.row_end)
                        report_mismatch("last_in_row", PIX_W'(last_in_row),
                                        PIX_W'(e.row_end));
                    if (last_in_image !== e.img_end)
                        report_mismatch("last_in_image", PIX_W'(last_in_image),
                                        PIX_W'(e.img_end));
                end
                pixels_checked++;
            end

            if (hold_off_seen != hold_off_req)
            begin
                hold_off_seen = hold_off_req;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                if (res_valid && !res_stall)
                    res_gap = (((pixels_checked / 100) % 4) == 2) ? 0 : $urandom_range(0, 4);
                if (res_gap != 0)
                begin
                    res_gap--;
                    res_stall <= 1'b1;
                end
                else
                    res_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #RUN_LIMIT;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int random_sent;
        int w;
        int h;
        int size;

        // Directed rows: reset size, zero sizes, rounding, spare indexes, odd drops
        directed_rows = '{
            '{STEP_PIXEL, '0, '0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b1}},
            '{STEP_PIXEL, '0, '0, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b1}},
            '{STEP_WRITE, REG_SRC_WIDTH, 16'd0, '0, 1'b0, '0},
            '{STEP_WRITE, REG_SRC_HEIGHT, 16'd0, '0, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'h80FF_0001, 1'b1, '{32'h80FF_0001, 1'b1, 1'b1}},
            '{STEP_WRITE, REG_SRC_WIDTH, 16'd2, '0, 1'b0, '0},
            '{STEP_WRITE, REG_SRC_HEIGHT, 16'd1, '0, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'hFFFF_FFFF, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b1}},
            '{STEP_PIXEL, '0, '0, 32'h0000_0000, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'h0101_0101, 1'b1, '{32'h0101_0101, 1'b1, 1'b1}},
            '{STEP_WRITE, REG_SRC_HEIGHT, 16'd2, '0, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'hFFFF_FFFF, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'h0000_0000, 1'b0, '0},
            '{STEP_WRITE, REG_SPARE_3, 16'hFFFF, '0, 1'b0, '0},
            '{STEP_WRITE, REG_SPARE_2, 16'h0001, '0, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'hFFFF_FFFF, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'h0000_0000, 1'b1, '{32'h8080_8080, 1'b1, 1'b1}},
            '{STEP_WRITE, REG_SRC_WIDTH, 16'd3, '0, 1'b0, '0},
            '{STEP_WRITE, REG_SRC_HEIGHT, 16'd3, '0, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'h1234_5678, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'h9ABC_DEF0, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'hDEAD_BEEF, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'h0F0F_0F0F, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'hF0F0_F0F0, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'h55AA_55AA, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'h7F7F_7F7F, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'h8080_8080, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'h01FE_01FE, 1'b0, '0},
            '{STEP_WRITE, REG_SRC_WIDTH, 16'd1, '0, 1'b0, '0},
            '{STEP_WRITE, REG_SRC_HEIGHT, 16'd4, '0, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'h0000_0003, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'h0000_0000, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'hFFFF_FFFF, 1'b0, '0},
            '{STEP_PIXEL, '0, '0, 32'hFFFF_FFFE, 1'b0, '0}
        };

        // Predictor reset state
        held_px = '0;
        width_reg = SRC_W_BITS'(1);
        height_reg = SRC_H_BITS'(1);
        col_pos = '0;
        row_pos = '0;
        pixels_sent = 0;
        pixels_checked = 0;
        settings_written = 0;
        mismatches = 0;
        hold_off_req = 0;
        hold_off_seen = 0;
        hold_left = 0;
        res_gap = 0;
        random_sent = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == STEP_WRITE)
                write_reg(directed_rows[i].index, directed_rows[i].data);
            else
                send_pixel(directed_rows[i].pixel, directed_rows[i].typed,
                           directed_rows[i].want);
        end

        // Back-pressure: hold the result side while pixels keep coming, then drain
        write_reg(REG_SRC_WIDTH, 16'd2);
        write_reg(REG_SRC_HEIGHT, 16'd1);
        hold_off_req++;
        send_image_run(48);
        wait_drained();
        send_image_run(16);

        // Random images, mostly small, each one to two frames long
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0: w = 0;
                1, 2, 3, 4, 5: w = $urandom_range(9, 70);
                default: w = $urandom_range(1, 8);
            endcase
            h = (w > 8) ? $urandom_range(0, 4)
                        : (($urandom_range(0, 4) == 0) ? $urandom_range(8, 20)
                                                       : $urandom_range(0, 7));
            write_reg(REG_SRC_WIDTH, w[CFG_DATA_W-1:0]);
            if (w > 8 || $urandom_range(0, 3) != 0)
                write_reg(REG_SRC_HEIGHT, h[CFG_DATA_W-1:0]);
            size = ((width_reg == 0) ? 1 : width_reg) * ((height_reg == 0) ? 1 : height_reg);
            size = size + $urandom_range(0, size);
            send_image_run(size);
            random_sent += size;
        end

        // Extremes: masked and saturated width on one row, tallest height, one column
        write_reg(REG_SRC_WIDTH, 16'hFFFF);
        write_reg(REG_SRC_HEIGHT, 16'd1);
        send_image_run(24);
        write_reg(REG_SRC_WIDTH, CFG_DATA_W'(MAX_WIDTH_DEF));
        write_reg(REG_SRC_HEIGHT, 16'hFFFF);
        send_image_run(12);
        write_reg(REG_SRC_WIDTH, 16'd1);
        send_image_run(10);

        wait_drained();
        $display("Run covered %0d source pixels across %0d register writes.",
                 pixels_sent, settings_written);
        $display("Compared %0d output pixels; %0d field mismatches.",
                 pixels_checked, mismatches);
        if (mismatches == 0 && mip_pixels_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
